[rtl/cdq_pkg.sv]
// Package with the shared types and constants of the circular deque with search.
`default_nettype none

package cdq_pkg;

    localparam int DATA_W           = 32;
    localparam int OCC_W            = 7;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REPLACE    = 3'd4,
        OP_LOOKUP     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_START,
        FSM_POP_WAIT,
        FSM_SCAN,
        FSM_NBR_PRED,
        FSM_NBR_SUCC,
        FSM_FINISH
    } fsm_t;

endpackage

`default_nettype wire

[rtl/circular_deque_with_search_core.sv]
// Top level of the circular deque with search, built around one synchronous ring memory.
// A push or unknown operation goes through START and FINISH; a non-empty pop adds POP_WAIT.
// A replace or lookup on a non-empty ring reads entries in SCAN, one per cycle through the
// single memory read port; a matching lookup then reads its neighbours in NBR_PRED, NBR_SUCC.
// One operation is in progress at a time; the next input beat is taken once the result sits
// in the output register. Reset empties the ring; the memory contents are not cleared.
`default_nettype none

module circular_deque_with_search_core
    import cdq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [2:0]               kind,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic signed [DATA_W-1:0] new_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      removed_value,
    output logic                          found,
    output logic signed [DATA_W-1:0]      pred_value,
    output logic signed [DATA_W-1:0]      succ_value,
    output logic [OCC_W-1:0]              occupancy
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] f, input logic [CW-1:0] p);
        logic [IW+1:0] s;
        s = {2'b00, f} + (IW+2)'(p);
        if (s >= (IW+2)'(CAPACITY)) begin
            s = s - (IW+2)'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    logic [DATA_W-1:0] ring_mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [IW-1:0]     mem_raddr;

    fsm_t              state_reg, state_next;
    logic [IW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [2:0]        kind_reg, kind_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [DATA_W-1:0] nval_reg, nval_next;
    status_t           res_status_reg, res_status_next;
    logic              res_found_reg, res_found_next;
    logic [DATA_W-1:0] res_removed_reg, res_removed_next;
    logic [DATA_W-1:0] res_pred_reg, res_pred_next;
    logic [DATA_W-1:0] res_succ_reg, res_succ_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic              out_found_reg, out_found_next;
    logic [DATA_W-1:0] out_removed_reg, out_removed_next;
    logic [DATA_W-1:0] out_pred_reg, out_pred_next;
    logic [DATA_W-1:0] out_succ_reg, out_succ_next;
    logic [OCC_W-1:0]  out_occ_reg, out_occ_next;

    op_t                  op;
    logic                 match;
    logic                 last_pos;
    logic                 out_free;
    logic [CW+OCC_W-1:0]  occ_ext;

    assign op       = op_t'(kind_reg);
    assign match    = (rd_data_reg == value_reg);
    assign last_pos = (pos_reg == count_reg - CW'(1));
    assign out_free = !out_valid_reg || !out_stall;
    assign occ_ext  = {{OCC_W{1'b0}}, count_reg};

    always_ff @(posedge clk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[mem_raddr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_valid) begin
                    state_next = FSM_START;
                end
            end
            FSM_START: begin
                state_next = FSM_FINISH;
                if ((op == OP_POP_FRONT || op == OP_POP_BACK) && count_reg != '0) begin
                    state_next = FSM_POP_WAIT;
                end
                if ((op == OP_REPLACE || op == OP_LOOKUP) && count_reg != '0) begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_POP_WAIT: state_next = FSM_FINISH;
            FSM_SCAN: begin
                priority if (match) begin
                    state_next = (op == OP_LOOKUP) ? FSM_NBR_PRED : FSM_FINISH;
                end else if (last_pos) begin
                    state_next = FSM_FINISH;
                end else begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_NBR_PRED: state_next = FSM_NBR_SUCC;
            FSM_NBR_SUCC: state_next = FSM_FINISH;
            FSM_FINISH: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = nval_reg;
        mem_raddr        = '0;
        front_next       = front_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        nval_next        = nval_reg;
        res_status_next  = res_status_reg;
        res_found_next   = res_found_reg;
        res_removed_next = res_removed_reg;
        res_pred_next    = res_pred_reg;
        res_succ_next    = res_succ_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_removed_next = out_removed_reg;
        out_pred_next    = out_pred_reg;
        out_succ_next    = out_succ_reg;
        out_occ_next     = out_occ_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_valid) begin
                    kind_next        = kind;
                    value_next       = value;
                    nval_next        = new_value;
                    res_status_next  = ST_OK;
                    res_found_next   = 1'b0;
                    res_removed_next = '0;
                    res_pred_next    = '0;
                    res_succ_next    = '0;
                end
            end
            FSM_START: begin
                unique case (op)
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (count_reg == FULL_CNT) begin
                            res_status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_wdata  = value_reg;
                            count_next = count_reg + CW'(1);
                            if (op == OP_PUSH_FRONT) begin
                                front_next = (front_reg == '0) ? LAST_IDX
                                                               : front_reg - IW'(1);
                                mem_waddr  = front_next;
                            end else begin
                                mem_waddr = slot_of(front_reg, count_reg);
                            end
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            count_next = count_reg - CW'(1);
                            if (op == OP_POP_FRONT) begin
                                mem_raddr  = front_reg;
                                front_next = (front_reg == LAST_IDX) ? '0
                                                                     : front_reg + IW'(1);
                            end else begin
                                mem_raddr = slot_of(front_reg, count_reg - CW'(1));
                            end
                        end
                    end
                    OP_REPLACE, OP_LOOKUP: begin
                        res_status_next = ST_NOT_FOUND;
                        if (count_reg == '0) begin
                            if (op == OP_LOOKUP) begin
                                res_status_next = ST_EMPTY;
                            end
                        end else begin
                            mem_raddr = front_reg;
                            pos_next  = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FSM_POP_WAIT: begin
                res_removed_next = rd_data_reg;
            end
            FSM_SCAN: begin
                priority if (match) begin
                    res_status_next = ST_OK;
                    res_found_next  = 1'b1;
                    if (op == OP_LOOKUP) begin
                        mem_raddr = slot_of(front_reg,
                            (pos_reg == '0) ? count_reg - CW'(1) : pos_reg - CW'(1));
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(front_reg, pos_reg);
                        mem_wdata = nval_reg;
                    end
                end else if (last_pos) begin
                    res_status_next = ST_NOT_FOUND;
                end else begin
                    mem_raddr = slot_of(front_reg, pos_reg + CW'(1));
                    pos_next  = pos_reg + CW'(1);
                end
            end
            FSM_NBR_PRED: begin
                res_pred_next = rd_data_reg;
                mem_raddr = slot_of(front_reg, last_pos ? '0 : pos_reg + CW'(1));
            end
            FSM_NBR_SUCC: begin
                res_succ_next = rd_data_reg;
            end
            FSM_FINISH: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_found_next   = res_found_reg;
                    out_removed_next = res_removed_reg;
                    out_pred_next    = res_pred_reg;
                    out_succ_next    = res_succ_reg;
                    out_occ_next     = occ_ext[OCC_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= FSM_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        pos_reg         <= pos_next;
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        nval_reg        <= nval_next;
        res_status_reg  <= res_status_next;
        res_found_reg   <= res_found_next;
        res_removed_reg <= res_removed_next;
        res_pred_reg    <= res_pred_next;
        res_succ_reg    <= res_succ_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_removed_reg <= out_removed_next;
        out_pred_reg    <= out_pred_next;
        out_succ_reg    <= out_succ_next;
        out_occ_reg     <= out_occ_next;
    end

    assign in_stall      = (state_reg != FSM_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found         = out_found_reg;
    assign removed_value = out_removed_reg;
    assign pred_value    = out_pred_reg;
    assign succ_value    = out_succ_reg;
    assign occupancy     = out_occ_reg;

endmodule

`default_nettype wire
